// ===== rtl/aas_pkg.sv =====
package aas_pkg;

    // Operation codes of the action field.
    typedef enum logic [4:0] {
        ACT_ADD  = 5'd0,
        ACT_SUB  = 5'd1,
        ACT_SMIN = 5'd2,
        ACT_SMAX = 5'd3,
        ACT_UMIN = 5'd4,
        ACT_UMAX = 5'd5,
        ACT_SDIV = 5'd6,
        ACT_SMOD = 5'd7,
        ACT_UDIV = 5'd8,
        ACT_UMOD = 5'd9,
        ACT_MUL  = 5'd10,
        ACT_AND  = 5'd11,
        ACT_OR   = 5'd12,
        ACT_XOR  = 5'd13,
        ACT_STO  = 5'd14,
        ACT_RST  = 5'd15,
        ACT_STOP = 5'd16,
        ACT_ROR  = 5'd17,
        ACT_SCMP = 5'd18,
        ACT_UCMP = 5'd19,
        ACT_SHL  = 5'd20,
        ACT_SHR  = 5'd21,
        ACT_SAR  = 5'd22
    } aas_action_t;

    // Operand width codes.
    localparam logic [1:0] WM_BYTE  = 2'd0;
    localparam logic [1:0] WM_WORD  = 2'd1;
    localparam logic [1:0] WM_DWORD = 2'd2;

    // Pre-adjust codes.
    localparam logic [1:0] PRE_NONE = 2'd0;
    localparam logic [1:0] PRE_DIV  = 2'd1;
    localparam logic [1:0] PRE_MOD  = 2'd2;

    // Store request codes.
    localparam logic [1:0] STORE_NONE = 2'd0;
    localparam logic [1:0] STORE_TEMP = 2'd1;
    localparam logic [1:0] STORE_PERM = 2'd2;

    // Comparison result codes.
    localparam logic [31:0] CMP_LESS    = 32'd0;
    localparam logic [31:0] CMP_EQUAL   = 32'd1;
    localparam logic [31:0] CMP_GREATER = 32'd2;

    // Shift and rotate amounts use the low five bits.
    localparam logic [31:0] SHIFT_MASK = 32'h1F;

    // Beat payload carried alongside the pre-adjust divider.
    typedef struct packed {
        logic [4:0]  action;
        logic [1:0]  width_mode;
        logic        do_pre;
        logic        pre_mod;
        logic        fault;
        logic        neg_q;
        logic        neg_r;
        logic [31:0] value;
        logic [31:0] acc;
    } aas_pre_sb_t;

    // Beat payload carried alongside the operation divider.
    typedef struct packed {
        logic [4:0]  action;
        logic [1:0]  width_mode;
        logic        fault;
        logic        neg_q;
        logic        neg_r;
        logic [31:0] value;
        logic [31:0] acc;
    } aas_op_sb_t;

    // Zero-extend from the operand width.
    function automatic logic [31:0] trunc_w(input logic [31:0] v, input logic [1:0] wm);
        logic [31:0] r;
        case (wm)
            WM_BYTE: r = {24'd0, v[7:0]};
            WM_WORD: r = {16'd0, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    // Sign-extend from the operand width.
    function automatic logic [31:0] sext_w(input logic [31:0] v, input logic [1:0] wm);
        logic [31:0] r;
        case (wm)
            WM_BYTE: r = {{24{v[7]}}, v[7:0]};
            WM_WORD: r = {{16{v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/aas_div_pipe.sv =====
module aas_div_pipe #(
    parameter int DW = 33,
    parameter int VW = 32,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder,
    output logic [SW-1:0] out_side
);

    logic          valid_reg [DW];
    logic [VW-1:0] rem_reg   [DW];
    logic [DW-1:0] dq_reg    [DW];
    logic [VW-1:0] dsr_reg   [DW];
    logic [SW-1:0] side_reg  [DW];

    // One quotient bit per stage, restoring form.
    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic          valid_in;
        logic [VW-1:0] rem_in;
        logic [DW-1:0] dq_in;
        logic [VW-1:0] dsr_in;
        logic [SW-1:0] side_in;
        logic [VW:0]   partial;
        logic [VW:0]   diff;
        logic          ge;
        logic [VW-1:0] rem_next;
        logic [DW-1:0] dq_next;

        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = '0;
            assign dq_in    = dividend;
            assign dsr_in   = divisor;
            assign side_in  = in_side;
        end
        else begin : g_next
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign dq_in    = dq_reg[k-1];
            assign dsr_in   = dsr_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        // Trial subtract of the divisor from the shifted partial remainder.
        always_comb
        begin
            partial  = {rem_in, dq_in[DW-1]};
            diff     = partial - {1'b0, dsr_in};
            ge       = (partial >= {1'b0, dsr_in});
            rem_next = ge ? diff[VW-1:0] : partial[VW-1:0];
            dq_next  = {dq_in[DW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            dq_reg[k]   <= dq_next;
            dsr_reg[k]  <= dsr_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = valid_reg[DW-1];
    assign quotient  = dq_reg[DW-1];
    assign remainder = rem_reg[DW-1];
    assign out_side  = side_reg[DW-1];

endmodule

// ===== rtl/aas_op_stage.sv =====
module aas_op_stage
    import aas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  aas_op_sb_t  side,
    input  logic [31:0] quotient,
    input  logic [31:0] remainder,
    output logic        done,
    output logic [31:0] new_value,
    output logic [1:0]  store_kind,
    output logic [31:0] store_index,
    output logic [31:0] store_data,
    output logic        divide_fault
);

    logic [31:0] acc;
    logic [31:0] value;
    logic [31:0] uv;
    logic [31:0] sa;
    logic [31:0] sv;
    logic [4:0]  amt;
    logic [31:0] q_pat;
    logic [31:0] r_pat;
    logic [63:0] rot;
    logic [31:0] r;
    logic [1:0]  kind;
    logic [31:0] sidx;
    logic [31:0] sdata;

    logic        done_reg;
    logic [31:0] value_reg;
    logic [1:0]  kind_reg;
    logic [31:0] sidx_reg;
    logic [31:0] sdata_reg;
    logic        fault_reg;

    // Operands at the width and signed fix-up of the divider result.
    always_comb
    begin
        acc   = side.acc;
        value = side.value;
        uv    = trunc_w(value, side.width_mode);
        sa    = sext_w(acc, side.width_mode);
        sv    = sext_w(value, side.width_mode);
        amt   = uv[4:0] & SHIFT_MASK[4:0];
        q_pat = side.neg_q ? (32'd0 - quotient) : quotient;
        r_pat = side.neg_r ? (32'd0 - remainder) : remainder;
        rot   = {acc, acc} >> amt;
    end

    // Operation select.
    always_comb
    begin
        kind  = STORE_NONE;
        sidx  = '0;
        sdata = '0;
        case (side.action)
            ACT_ADD:  r = acc + value;
            ACT_SUB:  r = acc - value;
            ACT_SMIN: r = ($signed(sa) < $signed(sv)) ? sa : sv;
            ACT_SMAX: r = ($signed(sa) > $signed(sv)) ? sa : sv;
            ACT_UMIN: r = (acc < uv) ? acc : uv;
            ACT_UMAX: r = (acc > uv) ? acc : uv;
            ACT_SDIV, ACT_UDIV: r = (uv == 32'd0) ? acc : q_pat;
            ACT_SMOD, ACT_UMOD: r = (uv == 32'd0) ? acc : r_pat;
            ACT_MUL:  r = acc * value;
            ACT_AND:  r = acc & value;
            ACT_OR:   r = acc | value;
            ACT_XOR:  r = acc ^ value;
            ACT_STO, ACT_STOP:
            begin
                kind  = (side.action == ACT_STO) ? STORE_TEMP : STORE_PERM;
                sidx  = uv;
                sdata = sa;
                r     = acc;
            end
            ACT_ROR:  r = rot[31:0];
            ACT_SCMP: r = (sa == sv) ? CMP_EQUAL :
                          (($signed(sa) < $signed(sv)) ? CMP_LESS : CMP_GREATER);
            ACT_UCMP: r = (acc == uv) ? CMP_EQUAL : ((acc < uv) ? CMP_LESS : CMP_GREATER);
            ACT_SHL:  r = acc << amt;
            ACT_SHR:  r = acc >> amt;
            ACT_SAR:  r = $unsigned($signed(sa) >>> amt);
            default:  r = value;
        endcase
    end

    // Output register: one strobed beat per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= trunc_w(r, side.width_mode);
        kind_reg  <= kind;
        sidx_reg  <= sidx;
        sdata_reg <= sdata;
        fault_reg <= side.fault;
    end

    assign done         = done_reg;
    assign new_value    = value_reg;
    assign store_kind   = kind_reg;
    assign store_index  = sidx_reg;
    assign store_data   = sdata_reg;
    assign divide_fault = fault_reg;

endmodule

// ===== rtl/adjust_alu_step.sv =====
// Adjust step of a scripted expression ALU, fully pipelined. A new item may be
// started in every clock cycle; busy is never raised. Each item gives exactly
// one result beat, shown on done after passing through one input register, a
// 33-stage pre-adjust divider (one quotient bit per stage), one register, a
// 32-stage operation divider and one output register. Results come out in
// start order and must be taken when shown.
module adjust_alu_step
    import aas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  action,
    input  logic [1:0]  width_mode,
    input  logic [1:0]  pre_adjust,
    input  logic [4:0]  shift_amount,
    input  logic [31:0] value_mask,
    input  logic [31:0] add_value,
    input  logic [31:0] divisor,
    input  logic [31:0] accumulator,
    input  logic [31:0] variable_value,
    output logic        done,
    output logic [31:0] new_value,
    output logic [1:0]  store_kind,
    output logic [31:0] store_index,
    output logic signed [31:0] store_data,
    output logic        divide_fault
);

    localparam int PRE_SW = $bits(aas_pre_sb_t);
    localparam int OP_SW  = $bits(aas_op_sb_t);

    logic        in_valid_reg;
    logic [4:0]  action_reg;
    logic [1:0]  wm_reg;
    logic [1:0]  pre_reg;
    logic [4:0]  shift_reg;
    logic [31:0] mask_reg;
    logic [31:0] addv_reg;
    logic [31:0] divv_reg;
    logic [31:0] acc_reg;
    logic [31:0] var_reg;

    logic [31:0] masked;
    logic [31:0] sv32;
    logic [31:0] sadd32;
    logic [31:0] d32;
    logic [31:0] sum32;
    logic [32:0] sum33;
    logic [32:0] s33;
    logic [32:0] s_abs;
    logic [31:0] d_abs;
    aas_pre_sb_t pre_side;

    logic        pa_valid;
    logic [32:0] pa_q;
    logic [31:0] pa_r;
    logic [PRE_SW-1:0] pa_side_bits;
    aas_pre_sb_t pa_side;
    logic [32:0] pa_q_pat;
    logic [31:0] pa_r_pat;

    logic        mid_valid_reg;
    aas_op_sb_t  mid_reg;
    aas_op_sb_t  mid_next;

    logic        signed_op;
    logic [31:0] m_uv;
    logic [31:0] m_sa;
    logic [31:0] m_sv;
    logic [31:0] op_dividend;
    logic [31:0] op_divisor;
    aas_op_sb_t  op_side;

    logic        ob_valid;
    logic [31:0] ob_q;
    logic [31:0] ob_r;
    logic [OP_SW-1:0] ob_side_bits;

    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action;
        wm_reg     <= width_mode;
        pre_reg    <= pre_adjust;
        shift_reg  <= shift_amount;
        mask_reg   <= value_mask;
        addv_reg   <= add_value;
        divv_reg   <= divisor;
        acc_reg    <= accumulator;
        var_reg    <= variable_value;
    end

    // Shift, mask and the signed pre-adjust operands.
    always_comb
    begin
        masked = (var_reg >> shift_reg) & mask_reg;
        sv32   = sext_w(masked, wm_reg);
        sadd32 = sext_w(addv_reg, wm_reg);
        d32    = sext_w(divv_reg, wm_reg);
        sum32  = sv32 + sadd32;
        sum33  = {sv32[31], sv32} + {sadd32[31], sadd32};
        s33    = (wm_reg == WM_BYTE || wm_reg == WM_WORD) ? sum33 : {sum32[31], sum32};
        s_abs  = s33[32] ? (33'd0 - s33) : s33;
        d_abs  = d32[31] ? (32'd0 - d32) : d32;

        pre_side.action     = action_reg;
        pre_side.width_mode = wm_reg;
        pre_side.do_pre     = (pre_reg == PRE_DIV) || (pre_reg == PRE_MOD);
        pre_side.pre_mod    = (pre_reg == PRE_MOD);
        pre_side.fault      = pre_side.do_pre && (d32 == 32'd0);
        pre_side.neg_q      = s33[32] ^ d32[31];
        pre_side.neg_r      = s33[32];
        pre_side.value      = masked;
        pre_side.acc        = trunc_w(acc_reg, wm_reg);
    end

    aas_div_pipe #(
        .DW (33),
        .VW (32),
        .SW (PRE_SW)
    ) u_pre_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .dividend  (s_abs),
        .divisor   (d_abs),
        .in_side   (pre_side),
        .out_valid (pa_valid),
        .quotient  (pa_q),
        .remainder (pa_r),
        .out_side  (pa_side_bits)
    );

    // Sign fix-up of the pre-adjust and choice of the adjusted value.
    always_comb
    begin
        pa_side  = aas_pre_sb_t'(pa_side_bits);
        pa_q_pat = pa_side.neg_q ? (33'd0 - pa_q) : pa_q;
        pa_r_pat = pa_side.neg_r ? (32'd0 - pa_r) : pa_r;

        mid_next.action     = pa_side.action;
        mid_next.width_mode = pa_side.width_mode;
        mid_next.fault      = pa_side.fault;
        mid_next.neg_q      = 1'b0;
        mid_next.neg_r      = 1'b0;
        mid_next.acc        = pa_side.acc;
        if (pa_side.do_pre && !pa_side.fault)
        begin
            mid_next.value = pa_side.pre_mod ? pa_r_pat : pa_q_pat[31:0];
        end
        else
        begin
            mid_next.value = pa_side.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= pa_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
    end

    // Operands of the operation divider, signed or unsigned.
    always_comb
    begin
        signed_op = (mid_reg.action == ACT_SDIV) || (mid_reg.action == ACT_SMOD);
        m_uv      = trunc_w(mid_reg.value, mid_reg.width_mode);
        m_sa      = sext_w(mid_reg.acc, mid_reg.width_mode);
        m_sv      = sext_w(mid_reg.value, mid_reg.width_mode);
        if (signed_op)
        begin
            op_dividend = m_sa[31] ? (32'd0 - m_sa) : m_sa;
            op_divisor  = m_sv[31] ? (32'd0 - m_sv) : m_sv;
        end
        else
        begin
            op_dividend = mid_reg.acc;
            op_divisor  = m_uv;
        end
        op_side       = mid_reg;
        op_side.neg_q = signed_op && (m_sa[31] ^ m_sv[31]);
        op_side.neg_r = signed_op && m_sa[31];
    end

    aas_div_pipe #(
        .DW (32),
        .VW (32),
        .SW (OP_SW)
    ) u_op_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid_reg),
        .dividend  (op_dividend),
        .divisor   (op_divisor),
        .in_side   (op_side),
        .out_valid (ob_valid),
        .quotient  (ob_q),
        .remainder (ob_r),
        .out_side  (ob_side_bits)
    );

    aas_op_stage u_op (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (ob_valid),
        .side         (aas_op_sb_t'(ob_side_bits)),
        .quotient     (ob_q),
        .remainder    (ob_r),
        .done         (done),
        .new_value    (new_value),
        .store_kind   (store_kind),
        .store_index  (store_index),
        .store_data   (store_data),
        .divide_fault (divide_fault)
    );

endmodule

// ===== dv/adjust_alu_step_tb.sv =====
module adjust_alu_step_tb;
    import aas_pkg::*;

    // One input beat of the adjust step.
    typedef struct packed {
        logic [4:0]  action;
        logic [1:0]  width_mode;
        logic [1:0]  pre_adjust;
        logic [4:0]  shift_amount;
        logic [31:0] value_mask;
        logic [31:0] add_value;
        logic [31:0] divisor;
        logic [31:0] accumulator;
        logic [31:0] variable_value;
    } step_in_t;

    // One result beat.
    typedef struct packed {
        logic [31:0] new_value;
        logic [1:0]  store_kind;
        logic [31:0] store_index;
        logic [31:0] store_data;
        logic        divide_fault;
    } step_out_t;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int LATENCY = 68;
    localparam int RANDOM_ITEMS = 900;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [4:0]  action;
    logic [1:0]  width_mode;
    logic [1:0]  pre_adjust;
    logic [4:0]  shift_amount;
    logic [31:0] value_mask;
    logic [31:0] add_value;
    logic [31:0] divisor;
    logic [31:0] accumulator;
    logic [31:0] variable_value;
    logic        done;
    logic [31:0] new_value;
    logic [1:0]  store_kind;
    logic [31:0] store_index;
    logic signed [31:0] store_data;
    logic        divide_fault;

    step_in_t  pending_items[$];
    step_out_t expected_results[$];
    bit        stimulus_loaded;
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        burst_left;
    int        gap_left;

    adjust_alu_step dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .width_mode(width_mode), .pre_adjust(pre_adjust),
        .shift_amount(shift_amount), .value_mask(value_mask), .add_value(add_value),
        .divisor(divisor), .accumulator(accumulator),
        .variable_value(variable_value), .done(done), .new_value(new_value),
        .store_kind(store_kind), .store_index(store_index),
        .store_data(store_data), .divide_fault(divide_fault)
    );

    always #4 clk = ~clk;

    // Width in bits for a width code; the unused code acts as dword.
    function automatic int operand_bits(logic [1:0] wm);
        if (wm == WM_BYTE) return 8;
        if (wm == WM_WORD) return 16;
        return 32;
    endfunction

    function automatic logic [31:0] zext_at(logic [31:0] v, int bits);
        if (bits == 32) return v;
        return v & ((32'd1 << bits) - 32'd1);
    endfunction

    function automatic longint sext_at(logic [31:0] v, int bits);
        logic [31:0] t;
        longint r;
        t = zext_at(v, bits);
        r = longint'({32'd0, t});
        if (t[bits - 1]) r = r - (longint'(1) << bits);
        return r;
    endfunction

    // Expected result of one adjust step.
    function automatic step_out_t compute_step(step_in_t it);
        step_out_t o;
        int bits;
        logic [31:0] acc;
        logic [31:0] val;
        logic [31:0] uv;
        logic [31:0] r;
        logic [63:0] prod;
        longint d;
        longint s;
        longint sa;
        longint sv;
        int amt;
        bits = operand_bits(it.width_mode);
        acc = zext_at(it.accumulator, bits);
        val = (it.variable_value >> it.shift_amount) & it.value_mask;
        o = '0;
        // Pre-adjust: signed add, then divide or remainder; zero divisor faults.
        if (it.pre_adjust == PRE_DIV || it.pre_adjust == PRE_MOD) begin
            d = sext_at(it.divisor, bits);
            if (d == 0) begin
                o.divide_fault = 1'b1;
            end
            else begin
                s = sext_at(val, bits) + sext_at(it.add_value, bits);
                if (bits == 32) s = sext_at(s[31:0], 32);
                if (it.pre_adjust == PRE_DIV) s = s / d;
                else s = s % d;
                val = s[31:0];
            end
        end
        uv = zext_at(val, bits);
        sa = sext_at(acc, bits);
        sv = sext_at(val, bits);
        amt = int'(uv & SHIFT_MASK);
        case (it.action)
            ACT_ADD:  r = acc + val;
            ACT_SUB:  r = acc - val;
            ACT_SMIN: r = (sa < sv) ? sa[31:0] : sv[31:0];
            ACT_SMAX: r = (sa > sv) ? sa[31:0] : sv[31:0];
            ACT_UMIN: r = (acc < uv) ? acc : uv;
            ACT_UMAX: r = (acc > uv) ? acc : uv;
            ACT_SDIV: begin
                s = sa / ((uv == 0) ? 1 : sv);
                r = (uv == 0) ? acc : s[31:0];
            end
            ACT_SMOD: begin
                s = sa % ((uv == 0) ? 1 : sv);
                r = (uv == 0) ? acc : s[31:0];
            end
            ACT_UDIV: r = (uv == 0) ? acc : acc / uv;
            ACT_UMOD: r = (uv == 0) ? acc : acc % uv;
            ACT_MUL: begin
                prod = {32'd0, acc} * {32'd0, val};
                r = prod[31:0];
            end
            ACT_AND:  r = acc & val;
            ACT_OR:   r = acc | val;
            ACT_XOR:  r = acc ^ val;
            ACT_STO, ACT_STOP: begin
                o.store_kind = (it.action == ACT_STO) ? STORE_TEMP : STORE_PERM;
                o.store_index = uv;
                o.store_data = sa[31:0];
                r = acc;
            end
            ACT_ROR:  r = (amt == 0) ? acc : ((acc >> amt) | (acc << (32 - amt)));
            ACT_SCMP: r = (sa == sv) ? CMP_EQUAL : ((sa < sv) ? CMP_LESS : CMP_GREATER);
            ACT_UCMP: r = (acc == uv) ? CMP_EQUAL : ((acc < uv) ? CMP_LESS : CMP_GREATER);
            ACT_SHL:  r = acc << amt;
            ACT_SHR:  r = acc >> amt;
            ACT_SAR:  r = $signed(sa[31:0]) >>> amt;
            default:  r = val;
        endcase
        o.new_value = zext_at(r, bits);
        return o;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000 >> ($urandom_range(0, 2) * 8 + 8 * 0) >> 0;
            3: return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic step_in_t random_item();
        step_in_t it;
        it.action = ($urandom_range(0, 99) < 90) ? 5'($urandom_range(0, 22))
                                                 : 5'($urandom_range(23, 31));
        it.width_mode = 2'($urandom_range(0, 3));
        it.pre_adjust = 2'($urandom_range(0, 3));
        it.shift_amount = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom);
        it.value_mask = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom;
        it.add_value = pick_word();
        it.divisor = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_word();
        it.accumulator = pick_word();
        it.variable_value = pick_word();
        return it;
    endfunction

    function automatic step_in_t make_item(logic [4:0] act, logic [1:0] wm, logic [1:0] pre,
                                           logic [31:0] acc, logic [31:0] val,
                                           logic [31:0] addv, logic [31:0] dv);
        step_in_t it;
        it.action = act;
        it.width_mode = wm;
        it.pre_adjust = pre;
        it.shift_amount = 5'd0;
        it.value_mask = 32'hFFFF_FFFF;
        it.add_value = addv;
        it.divisor = dv;
        it.accumulator = acc;
        it.variable_value = val;
        return it;
    endfunction

    // Stimulus: directed corner cases first, then random items.
    initial
    begin
        step_in_t it;
        for (int a = 0; a <= 22; a++) begin
            pending_items.push_back(make_item(5'(a), 2'(a % 3), PRE_NONE, 32'h8000_0085,
                                              32'h0000_0003, 32'd0, 32'd1));
        end
        // Signed minimum over minus one, operation divisor zero.
        pending_items.push_back(make_item(ACT_SDIV, WM_DWORD, PRE_NONE, 32'h8000_0000,
                                          32'hFFFF_FFFF, 32'd0, 32'd1));
        pending_items.push_back(make_item(ACT_SMOD, WM_BYTE, PRE_NONE, 32'h80, 32'hFF, 0, 1));
        pending_items.push_back(make_item(ACT_UDIV, WM_WORD, PRE_NONE, 32'h1234, 32'h1_0000,
                                          0, 1));
        // Pre-adjust zero divisor and a byte-width exact sum.
        pending_items.push_back(make_item(ACT_ADD, WM_BYTE, PRE_DIV, 32'd5, 32'h7F, 0, 32'h100));
        pending_items.push_back(make_item(ACT_ADD, WM_BYTE, PRE_MOD, 32'd0, 32'h7F, 32'h7F, 32'h3));
        // Unused width and pre-adjust codes.
        pending_items.push_back(make_item(ACT_SHR, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'h1F, 0, 0));
        it = make_item(ACT_STOP, WM_DWORD, PRE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF);
        it.shift_amount = 5'd31;
        pending_items.push_back(it);
        for (int i = 0; i < RANDOM_ITEMS; i++) pending_items.push_back(random_item());
        stimulus_loaded = 1'b1;
    end

    // Driver: bursts of start beats with random gaps; busy holds the beat.
    always @(posedge clk or negedge rst_n)
    begin
        step_in_t it;
        if (!rst_n) begin
            start <= 1'b0;
            {action, width_mode, pre_adjust, shift_amount, value_mask, add_value,
             divisor, accumulator, variable_value} <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else begin
            if (start && !busy) begin
                expected_results.push_back(compute_step({action, width_mode, pre_adjust,
                    shift_amount, value_mask, add_value, divisor, accumulator,
                    variable_value}));
            end
            if (start && busy) begin
                // Hold the current beat.
            end
            else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                {action, width_mode, pre_adjust, shift_amount, value_mask, add_value,
                 divisor, accumulator, variable_value} <= it;
                start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end
                else begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        step_out_t got;
        step_out_t want;
        if (rst_n && done) begin
            got = {new_value, store_kind, store_index, store_data, divide_fault};
            if (expected_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) $display("unexpected beat: %h", got);
            end
            else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) begin
                        $display("mismatch: nv %h/%h kind %0d/%0d idx %h/%h data %h/%h flt %b/%b",
                                 want.new_value, got.new_value, want.store_kind,
                                 got.store_kind, want.store_index, got.store_index,
                                 want.store_data, got.store_data, want.divide_fault,
                                 got.divide_fault);
                    end
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Reset, then wait for the run to drain.
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait (stimulus_loaded);
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/aas_pkg.sv
rtl/aas_div_pipe.sv
rtl/aas_op_stage.sv
rtl/adjust_alu_step.sv
dv/adjust_alu_step_tb.sv
